// File: rtl/yrbsl_pkg.sv
// Shared types, register codes and arithmetic helpers for the bright spot locator.
`timescale 1ns / 1ps
`default_nettype none

package yrbsl_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_IMAGE_WIDTH      = 3'd0;
  localparam logic [2:0] CFG_BRIGHT_THRESHOLD = 3'd1;
  localparam logic [2:0] CFG_BACK_ROW_LIMIT   = 3'd2;
  localparam logic [2:0] CFG_LEFT_COL_LIMIT   = 3'd3;
  localparam logic [2:0] CFG_RIGHT_COL_LIMIT  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [11:0] RST_IMAGE_WIDTH      = 12'd640;
  localparam logic [7:0]  RST_BRIGHT_THRESHOLD = 8'd230;
  localparam logic [10:0] RST_BACK_ROW_LIMIT   = 11'd120;
  localparam logic [10:0] RST_LEFT_COL_LIMIT   = 11'd160;
  localparam logic [10:0] RST_RIGHT_COL_LIMIT  = 11'd480;

  // Steering directions.
  localparam logic [1:0] DIR_BACK    = 2'd0;
  localparam logic [1:0] DIR_LEFT    = 2'd1;
  localparam logic [1:0] DIR_RIGHT   = 2'd2;
  localparam logic [1:0] DIR_FORWARD = 2'd3;

  localparam int SUM_W = 20;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic        valid;
    logic [10:0] column;
    logic [10:0] row;
    logic [1:0]  direction;
  } hit_t;

  // Drop the rounding fraction and clamp to 0..255.
  function automatic logic [7:0] clamp_ch(input logic signed [SUM_W-1:0] s);
    logic [7:0] v;
    if (s[SUM_W-1]) begin
      v = 8'd0;
    end else if (|s[SUM_W-2:16]) begin
      v = 8'd255;
    end else begin
      v = s[15:8];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/yrbsl_convert.sv
// One pixel of BT.601 YUV to RGB conversion with clamping and the bright test.
`timescale 1ns / 1ps
`default_nettype none

module yrbsl_convert (
  input  wire logic [7:0]   luma,
  input  wire logic [7:0]   blue_diff,
  input  wire logic [7:0]   red_diff,
  input  wire logic [7:0]   threshold,
  output yrbsl_pkg::pix_t   pix,
  output logic              bright
);
  import yrbsl_pkg::*;

  logic signed [SUM_W-1:0] c_s, d_s, e_s;
  logic signed [SUM_W-1:0] luma_term;
  logic signed [SUM_W-1:0] sum_r, sum_g, sum_b;

  always_comb begin
    c_s = $signed({12'd0, luma}) - 20'sd16;
    d_s = $signed({12'd0, blue_diff}) - 20'sd128;
    e_s = $signed({12'd0, red_diff}) - 20'sd128;
    luma_term = 20'sd298 * c_s + 20'sd128;
    sum_r = luma_term + 20'sd409 * e_s;
    sum_g = luma_term - 20'sd100 * d_s - 20'sd208 * e_s;
    sum_b = luma_term + 20'sd516 * d_s;
    pix.red   = clamp_ch(sum_r);
    pix.green = clamp_ch(sum_g);
    pix.blue  = clamp_ch(sum_b);
    bright = (pix.red >= threshold) && (pix.green >= threshold) &&
             (pix.blue >= threshold);
  end

endmodule

`default_nettype wire

// File: rtl/yrbsl_locator.sv
// Column and row tracking, first-hit detection and steering direction.
`timescale 1ns / 1ps
`default_nettype none

module yrbsl_locator (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                advance,
  input  wire logic                frame_start,
  input  wire logic                bright_any,
  input  wire logic [11:0]         image_width,
  input  wire logic [10:0]         back_row_limit,
  input  wire logic [10:0]         left_col_limit,
  input  wire logic [10:0]         right_col_limit,
  output yrbsl_pkg::hit_t          hit
);
  import yrbsl_pkg::*;

  logic [10:0] column_r, column_nxt;
  logic [10:0] row_r, row_nxt;
  logic        seen_r, seen_nxt;

  logic [10:0] col_cur, row_cur;
  logic        seen_cur;
  logic [11:0] col_step;

  always_comb begin
    // A frame start clears the position before this beat is placed.
    col_cur  = frame_start ? 11'd0 : column_r;
    row_cur  = frame_start ? 11'd0 : row_r;
    seen_cur = frame_start ? 1'b0 : seen_r;

    hit = '0;
    if (bright_any && !seen_cur) begin
      hit.valid  = 1'b1;
      hit.column = col_cur;
      hit.row    = row_cur;
      priority if (row_cur <= back_row_limit) begin
        hit.direction = DIR_BACK;
      end else if (col_cur <= left_col_limit) begin
        hit.direction = DIR_LEFT;
      end else if (col_cur >= right_col_limit) begin
        hit.direction = DIR_RIGHT;
      end else begin
        hit.direction = DIR_FORWARD;
      end
    end

    seen_nxt = seen_cur | hit.valid;
    col_step = {1'b0, col_cur} + 12'd2;
    if (col_step >= image_width || col_step[11]) begin
      column_nxt = 11'd0;
      row_nxt    = row_cur + 11'd1;
    end else begin
      column_nxt = col_step[10:0];
      row_nxt    = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= 11'd0;
      row_r    <= 11'd0;
      seen_r   <= 1'b0;
    end else if (advance) begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/yuyv_rgb_bright_spot_locator.sv
// Top level: YUYV to RGB conversion with bright spot location and steering.
//
// The input channel carries one YUYV macropixel per beat (two lumas, shared
// U and V, plus a frame start flag). The output channel returns one beat per
// input beat: both RGB pixels, clamped to 0..255, and a hit report that is
// set only on the first beat of a frame holding a bright pixel.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. The configuration port is a plain write port, to be used
// only while no beat is in flight.
// Path: one input register, then the conversion and position logic, then the
// output register, whose valid flag is out_valid; a stalled output holds a
// beat in the input register. Throughput is one beat per cycle while out_stall
// is low; the path is one constant-multiply sum and a clamp per channel.
// When out_stall is high and out_valid is set, the output register holds; the
// input register still takes one more beat if it is empty, then in_stall rises.
// Reset clears both valid flags, the column, row and hit flag, and loads the
// configuration registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module yuyv_rgb_bright_spot_locator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_first_luma,
  input  wire logic [7:0]  in_blue_diff,
  input  wire logic [7:0]  in_second_luma,
  input  wire logic [7:0]  in_red_diff,
  input  wire logic        in_frame_start,
  // Output channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red_even,
  output logic [7:0]       out_green_even,
  output logic [7:0]       out_blue_even,
  output logic [7:0]       out_red_odd,
  output logic [7:0]       out_green_odd,
  output logic [7:0]       out_blue_odd,
  output logic             out_hit_valid,
  output logic [10:0]      out_hit_column,
  output logic [10:0]      out_hit_row,
  output logic [1:0]       out_direction
);
  import yrbsl_pkg::*;

  // Configuration registers.
  logic [11:0] image_width_r;
  logic [7:0]  bright_threshold_r;
  logic [10:0] back_row_limit_r;
  logic [10:0] left_col_limit_r;
  logic [10:0] right_col_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r      <= RST_IMAGE_WIDTH;
      bright_threshold_r <= RST_BRIGHT_THRESHOLD;
      back_row_limit_r   <= RST_BACK_ROW_LIMIT;
      left_col_limit_r   <= RST_LEFT_COL_LIMIT;
      right_col_limit_r  <= RST_RIGHT_COL_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:      image_width_r      <= cfg_data;
        CFG_BRIGHT_THRESHOLD: bright_threshold_r <= cfg_data[7:0];
        CFG_BACK_ROW_LIMIT:   back_row_limit_r   <= cfg_data[10:0];
        CFG_LEFT_COL_LIMIT:   left_col_limit_r   <= cfg_data[10:0];
        CFG_RIGHT_COL_LIMIT:  right_col_limit_r  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic       s1_valid_r;
  logic [7:0] s1_y0_r, s1_u_r, s1_y1_r, s1_v_r;
  logic       s1_fs_r;
  logic       out_valid_r;
  logic       advance;
  logic       in_take;

  // The input stage moves forward unless the output register holds a beat
  // that the receiver is stalling.
  assign advance  = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_y0_r <= in_first_luma;
      s1_u_r  <= in_blue_diff;
      s1_y1_r <= in_second_luma;
      s1_v_r  <= in_red_diff;
      s1_fs_r <= in_frame_start;
    end
  end

  // Conversion of the two pixels of the macropixel.
  pix_t pix_even, pix_odd;
  logic bright_even, bright_odd;
  hit_t hit;

  yrbsl_convert u_conv_even (
    .luma      (s1_y0_r),
    .blue_diff (s1_u_r),
    .red_diff  (s1_v_r),
    .threshold (bright_threshold_r),
    .pix       (pix_even),
    .bright    (bright_even)
  );

  yrbsl_convert u_conv_odd (
    .luma      (s1_y1_r),
    .blue_diff (s1_u_r),
    .red_diff  (s1_v_r),
    .threshold (bright_threshold_r),
    .pix       (pix_odd),
    .bright    (bright_odd)
  );

  yrbsl_locator u_locator (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (advance),
    .frame_start     (s1_fs_r),
    .bright_any      (bright_even || bright_odd),
    .image_width     (image_width_r),
    .back_row_limit  (back_row_limit_r),
    .left_col_limit  (left_col_limit_r),
    .right_col_limit (right_col_limit_r),
    .hit             (hit)
  );

  // Output register.
  pix_t out_even_r, out_odd_r;
  hit_t out_hit_r;
  logic out_valid_nxt;

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_even_r <= pix_even;
      out_odd_r  <= pix_odd;
      out_hit_r  <= hit;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_even   = out_even_r.red;
  assign out_green_even = out_even_r.green;
  assign out_blue_even  = out_even_r.blue;
  assign out_red_odd    = out_odd_r.red;
  assign out_green_odd  = out_odd_r.green;
  assign out_blue_odd   = out_odd_r.blue;
  assign out_hit_valid  = out_hit_r.valid;
  assign out_hit_column = out_hit_r.column;
  assign out_hit_row    = out_hit_r.row;
  assign out_direction  = out_hit_r.direction;

endmodule

`default_nettype wire
